FILE: rtl/bsr_pkg.sv
// Package for the brush stroke rasterizer: register indexes, command codes and
// the item types passed between the front end and the painting back end.
// No dependencies.
`default_nettype none
package bsr_pkg;

  localparam int unsigned CfgAddrBits = 4;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BRUSH  = 2'd2,
    REG_COLOR  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_STROKE  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_OUTSIDE = 2'd2
  } cmd_t;

  // One classified item, handed from the front end to the back end.
  typedef struct packed {
    cmd_t        cmd;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic        right;
    logic        up;
    logic [8:0]  steps_x;
    logic [8:0]  steps_y;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/bsr_in_if.sv
// Input channel of the brush stroke rasterizer: valid/ready plus item fields.
// No dependencies.
`default_nettype none
interface bsr_in_if;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [8:0]       pos_x;
  logic [8:0]       pos_y;
  logic signed [8:0] move_x;
  logic signed [8:0] move_y;
  modport source (output valid, kind, pos_x, pos_y, move_x, move_y, input ready);
  modport sink (input valid, kind, pos_x, pos_y, move_x, move_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/bsr_out_if.sv
// Result channel of the brush stroke rasterizer: valid/ready plus result fields.
// No dependencies.
`default_nettype none
interface bsr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [8:0]  end_x;
  logic [8:0]  end_y;
  logic        status;
  modport source (output valid, pixel_value, end_x, end_y, status, input ready);
  modport sink (input valid, pixel_value, end_x, end_y, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/bsr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module bsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/bsr_front.sv
// Front end: accepts items, classifies them and clamps the walk step counts.
// Depends on bsr_pkg and bsr_in_if.
`default_nettype none
module bsr_front
  import bsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsr_in_if.sink     in_ch,
  input  wire logic [12:0] eff_w,
  input  wire logic [12:0] eff_h,
  output logic       job_valid,
  input  wire logic  job_ready,
  output job_t       job
);
  logic       full_r;
  job_t       job_r;
  job_t       job_nxt;
  logic [9:0] mag_x;
  logic [9:0] mag_y;
  logic [12:0] lim_x;
  logic [12:0] lim_y;
  logic [12:0] px;
  logic [12:0] py;

  assign in_ch.ready = !full_r || job_ready;
  assign job_valid = full_r;
  assign job = job_r;

  always_comb begin
    px = {4'd0, in_ch.pos_x};
    py = {4'd0, in_ch.pos_y};
    mag_x = in_ch.move_x[8] ? 10'(-$signed({in_ch.move_x[8], in_ch.move_x}))
                             : {1'b0, in_ch.move_x};
    mag_y = in_ch.move_y[8] ? 10'(-$signed({in_ch.move_y[8], in_ch.move_y}))
                             : {1'b0, in_ch.move_y};
    job_nxt.pos_x = in_ch.pos_x;
    job_nxt.pos_y = in_ch.pos_y;
    job_nxt.right = !in_ch.move_x[8] && (in_ch.move_x != '0);
    job_nxt.up    = !in_ch.move_y[8] && (in_ch.move_y != '0);
    lim_x = job_nxt.right ? eff_w - 13'd1 - px : px;
    lim_y = job_nxt.up ? py : eff_h - 13'd1 - py;
    job_nxt.steps_x = ({3'd0, mag_x} > lim_x) ? lim_x[8:0] : mag_x[8:0];
    job_nxt.steps_y = ({3'd0, mag_y} > lim_y) ? lim_y[8:0] : mag_y[8:0];
    if (px >= eff_w || py >= eff_h) begin
      job_nxt.cmd = CMD_OUTSIDE;
    end else if (in_ch.kind) begin
      job_nxt.cmd = CMD_READ;
    end else begin
      job_nxt.cmd = CMD_STROKE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      full_r <= 1'b1;
    end else if (job_ready) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      job_r <= job_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bsr_back.sv
// Back end: walks a stroke, stamps spans pixel by pixel into the canvas RAM,
// serves pixel reads and runs the clearing pass after reset.
// Depends on bsr_pkg, bsr_out_if and bsr_ram.
`default_nettype none
module bsr_back
  import bsr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  job_t             job,
  input  wire logic [12:0] eff_w,
  input  wire logic [12:0] eff_h,
  input  wire logic [5:0]  brush,
  input  wire logic [31:0] color,
  bsr_out_if.source        out_ch
);
  localparam int unsigned XB = $clog2(MAX_WIDTH);
  localparam int unsigned YB = $clog2(MAX_HEIGHT);
  localparam int unsigned AB = XB + YB;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_ROW, S_SPAN, S_STEP, S_OUT
  } state_t;

  state_t      state_r;
  logic [AB:0] clr_r;
  logic signed [13:0] x_r, y_r;
  logic signed [13:0] row_r;
  logic signed [13:0] col_r, hi_r;
  logic [5:0]  di_r;
  logic        neg_r;
  logic        right_r, up_r;
  logic [8:0]  sx_r, sy_r;
  logic [31:0] pix_r;
  logic        stat_r;
  logic [8:0]  ex_r, ey_r;

  logic              we;
  logic [AB-1:0]     waddr;
  logic [AB-1:0]     raddr;
  logic [PIXEL_BITS-1:0] wdata;
  logic [PIXEL_BITS-1:0] rdata;
  logic [5:0]        n_eff;
  logic signed [13:0] half, srow, lo, hi;

  bsr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign n_eff = (brush <= 6'd1) ? 6'd1 : brush;
  assign job_ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.pixel_value = pix_r;
  assign out_ch.end_x = ex_r;
  assign out_ch.end_y = ey_r;
  assign out_ch.status = stat_r;
  assign raddr = {YB'(job.pos_y), XB'(job.pos_x)};

  // Span for the row offset di: half width n-di (n at the centre), clipped.
  always_comb begin
    if (n_eff == 6'd1) begin
      half = 14'sd1;
    end else begin
      half = $signed({8'd0, n_eff - di_r});
    end
    srow = neg_r ? y_r - $signed({8'd0, di_r}) : y_r + $signed({8'd0, di_r});
    lo = x_r - half;
    hi = x_r + half;
    if (n_eff == 6'd1) begin
      hi = x_r + 14'sd1;
      lo = x_r;
    end
    if (lo < 0) lo = '0;
    if (hi > $signed({1'b0, eff_w})) hi = $signed({1'b0, eff_w});
  end

  always_comb begin
    we = 1'b0;
    waddr = {row_r[YB-1:0], col_r[XB-1:0]};
    wdata = color[PIXEL_BITS-1:0];
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_r[AB-1:0];
      wdata = '1;
    end else if (state_r == S_SPAN && col_r < hi_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AB+1)'(MAX_WIDTH * MAX_HEIGHT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            x_r <= $signed({5'd0, job.pos_x});
            y_r <= $signed({5'd0, job.pos_y});
            ex_r <= job.pos_x;
            ey_r <= job.pos_y;
            right_r <= job.right;
            up_r <= job.up;
            sx_r <= job.steps_x;
            sy_r <= job.steps_y;
            pix_r <= '0;
            stat_r <= 1'b0;
            di_r <= '0;
            neg_r <= 1'b0;
            unique case (job.cmd)
              CMD_OUTSIDE: begin
                stat_r <= 1'b1;
                state_r <= S_OUT;
              end
              CMD_READ: state_r <= S_READ;
              default: state_r <= S_ROW;
            endcase
          end
        end
        S_READ: begin
          pix_r <= 32'(rdata);
          state_r <= S_OUT;
        end
        S_ROW: begin
          // Set up one span; rows outside the canvas are skipped.
          row_r <= srow;
          col_r <= lo;
          hi_r <= (srow < 0 || srow >= $signed({1'b0, eff_h})) ? lo : hi;
          state_r <= S_SPAN;
        end
        S_SPAN: begin
          // The row below the centre is followed by its mirror above before
          // the offset grows.
          if (col_r < hi_r) begin
            col_r <= col_r + 14'sd1;
          end else if (!neg_r && di_r != '0) begin
            neg_r <= 1'b1;
            state_r <= S_ROW;
          end else if (n_eff == 6'd1 || {1'b0, di_r} + 7'd2 >= {1'b0, n_eff}) begin
            state_r <= S_STEP;
          end else begin
            neg_r <= 1'b0;
            di_r <= di_r + 6'd1;
            state_r <= S_ROW;
          end
        end
        S_STEP: begin
          di_r <= '0;
          neg_r <= 1'b0;
          if (sx_r == '0 && sy_r == '0) begin
            ex_r <= x_r[8:0];
            ey_r <= y_r[8:0];
            state_r <= S_OUT;
          end else begin
            if (sx_r != '0) begin
              x_r <= right_r ? x_r + 14'sd1 : x_r - 14'sd1;
              sx_r <= sx_r - 9'd1;
            end
            if (sy_r != '0) begin
              y_r <= up_r ? y_r - 14'sd1 : y_r + 14'sd1;
              sy_r <= sy_r - 9'd1;
            end
            state_r <= S_ROW;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/brush_stroke_rasterizer_core.sv
// Top level of the brush stroke rasterizer: configuration registers, front end,
// back end. Depends on bsr_pkg, bsr_in_if, bsr_out_if, bsr_front, bsr_back.
`default_nettype none
// The block keeps a MAX_WIDTH by MAX_HEIGHT canvas in one RAM and takes stroke
// and pixel-read items. After reset a clearing pass writes white to every
// pixel, one per cycle; during it one item can be accepted and held in the
// queue, but no further item is taken until the pass ends; configuration
// writes are taken. A read, once the back end is idle, passes from the queue
// register through S_READ, which captures the registered RAM read data, to
// S_OUT, which presents the result. A stroke is painted pixel by pixel, since
// every pixel goes through the single RAM write port: at each walk position
// every brush row is set up in S_ROW and written in S_SPAN, and S_STEP then
// takes the next walk step. The front end classifies and clamps the next item
// while the back end paints, through a one-entry queue between them.
module brush_stroke_rasterizer_core
  import bsr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  bsr_in_if.sink                      in_ch,
  bsr_out_if.source                   out_ch,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CfgAddrBits-1:0] cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  logic [9:0]  width_r, height_r;
  logic [5:0]  brush_r;
  logic [31:0] color_r;
  logic [12:0] eff_w, eff_h;
  logic        job_valid, job_ready;
  job_t        job;
  reg_idx_t    idx;

  assign cfg_pready = 1'b1;
  assign idx = reg_idx_t'(cfg_paddr[3:2]);

  // Register writes land only when the address is one of the four registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 10'd500;
      height_r <= 10'd500;
      brush_r <= 6'd1;
      color_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_WIDTH:  width_r <= cfg_pwdata[9:0];
        REG_HEIGHT: height_r <= cfg_pwdata[9:0];
        REG_BRUSH:  brush_r <= cfg_pwdata[5:0];
        REG_COLOR:  color_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  cfg_prdata = {22'd0, width_r};
      REG_HEIGHT: cfg_prdata = {22'd0, height_r};
      REG_BRUSH:  cfg_prdata = {26'd0, brush_r};
      default:    cfg_prdata = color_r;
    endcase
  end

  // Canvas sizes of zero act as one, and sizes over the maximum as the maximum.
  always_comb begin
    eff_w = (width_r == '0) ? 13'd1 : {3'd0, width_r};
    eff_h = (height_r == '0) ? 13'd1 : {3'd0, height_r};
    if (eff_w > 13'(MAX_WIDTH)) eff_w = 13'(MAX_WIDTH);
    if (eff_h > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
  end

  bsr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .eff_w(eff_w), .eff_h(eff_h),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  bsr_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .eff_w(eff_w), .eff_h(eff_h), .brush(brush_r), .color(color_r), .out_ch(out_ch)
  );
endmodule
`default_nettype wire
